>>> rtl/core/dca_pkg.sv
// Package for the drive command arbiter: payload types, codes, constants and stick scaling.
`timescale 1ns / 1ps
package dca_pkg;

  // Width of the saturating age counters
  localparam int AGE_WIDTH_DEF = 16;

  // Timeout register width and reset values
  localparam int TMO_WIDTH = 16;
  localparam logic [TMO_WIDTH-1:0] RC_TIMEOUT_RST    = 16'd100;
  localparam logic [TMO_WIDTH-1:0] UPPER_TIMEOUT_RST = 16'd500;
  localparam logic [TMO_WIDTH-1:0] MOTOR_TIMEOUT_RST = 16'd500;

  // Configuration register indexes
  localparam int CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RC_TIMEOUT    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_UPPER_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MOTOR_TIMEOUT = 2'd2;

  // Event codes
  localparam logic [2:0] FUNC_TICK        = 3'd0;
  localparam logic [2:0] FUNC_REMOTE      = 3'd1;
  localparam logic [2:0] FUNC_UPPER_CMD   = 3'd2;
  localparam logic [2:0] FUNC_UPPER_SPEED = 3'd3;
  localparam logic [2:0] FUNC_MOTOR       = 3'd4;

  // Control source codes
  localparam logic [1:0] SRC_IDLE   = 2'd0;
  localparam logic [1:0] SRC_REMOTE = 2'd1;
  localparam logic [1:0] SRC_HOST   = 2'd2;

  // Command kinds
  localparam logic KIND_STOP  = 1'b0;
  localparam logic KIND_SPEED = 1'b1;

  // Stop reasons
  localparam logic [2:0] REASON_NONE    = 3'd0;
  localparam logic [2:0] REASON_FORCED  = 3'd1;
  localparam logic [2:0] REASON_EMERG   = 3'd2;
  localparam logic [2:0] REASON_FAULT   = 3'd3;
  localparam logic [2:0] REASON_TIMEOUT = 3'd4;

  // Remote stick and switch levels
  localparam logic [10:0] STICK_LOW    = 11'd272;
  localparam logic [10:0] STICK_MID    = 11'd992;
  localparam logic [10:0] STICK_HIGH   = 11'd1712;
  localparam logic [10:0] DEAD_ZONE    = 11'd10;
  localparam logic [10:0] SWITCH_LEVEL = 11'd1000;

  // Scaling 720 counts to 500: multiply by 25, divide by 36 (= shift by 2, divide by 9)
  localparam int CMD_SPAN    = 500;
  localparam int STICK_SPAN  = 720;
  localparam int SCALE_GCD   = 20;
  localparam int SCALE_NUM   = CMD_SPAN / SCALE_GCD;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_DIV   = STICK_SPAN / SCALE_GCD / 4;
  localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + RECIP_DIV - 1) / RECIP_DIV;

  typedef struct packed {
    logic [2:0]  func;
    logic [10:0] stick_steer_raw;
    logic [10:0] stick_drive_raw;
    logic [10:0] emergency_raw;
    logic [10:0] enable_raw;
    logic        link_lost;
    logic [63:0] can_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  control_source;
    logic        command_kind;
    logic signed [15:0] speed_axis_one;
    logic signed [15:0] speed_axis_two;
    logic [2:0]  halt_cause;
    logic [2:0]  status_flags;
    logic [7:0]  motor_fault_code;
  } out_item_t;

  // Stick value after clamp and deadband, premultiplied
  typedef struct packed {
    logic        neg;
    logic [14:0] prod;
  } stick_pre_t;

  // Registered input beat handed to the core
  typedef struct packed {
    logic [2:0]  func;
    logic        link_lost;
    logic        enable_on;
    logic        emergency_on;
    stick_pre_t  steer;
    stick_pre_t  drive;
    logic [63:0] can_payload;
  } stage_t;

  // Clamp, deadband and first scaling multiply of a raw stick value
  function automatic stick_pre_t stick_prescale_f(input logic [10:0] raw);
    logic [10:0] v;
    logic [9:0]  d;
    stick_pre_t  res;
    v = raw;
    if (v < STICK_LOW) v = STICK_LOW;
    if (v > STICK_HIGH) v = STICK_HIGH;
    res.neg = (v < STICK_MID);
    if (v > (STICK_MID - DEAD_ZONE) && v < (STICK_MID + DEAD_ZONE)) begin
      d = 10'd0;
    end else if (res.neg) begin
      d = 10'(STICK_MID - v);
    end else begin
      d = 10'(v - STICK_MID);
    end
    res.prod = 15'(d) * 15'(SCALE_NUM);
    return res;
  endfunction

  // Second scaling step: truncating divide by 36 via reciprocal, then sign
  function automatic logic [9:0] stick_finish_f(input stick_pre_t pre);
    logic [12:0] m;
    logic [25:0] p;
    logic [8:0]  q;
    m = pre.prod[14:2];
    p = 26'(m) * 26'(RECIP_MUL);
    q = p[RECIP_SHIFT+8:RECIP_SHIFT];
    return pre.neg ? 10'(-10'(q)) : 10'(q);
  endfunction

endpackage

>>> rtl/core/dca_core.sv
// Arbiter state, timeout registers and the per-beat arbitration result.
`timescale 1ns / 1ps
module dca_core #(
  parameter int AGE_WIDTH = dca_pkg::AGE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  dca_pkg::stage_t                   stage,
  input  logic                              cfg_we,
  input  logic [dca_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [dca_pkg::TMO_WIDTH-1:0]     cfg_data,
  output dca_pkg::out_item_t                result
);

  localparam int CMP_WIDTH = (AGE_WIDTH > dca_pkg::TMO_WIDTH) ? AGE_WIDTH : dca_pkg::TMO_WIDTH;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
  localparam logic [AGE_WIDTH-1:0] AGE_ONE = AGE_WIDTH'(1);

  logic [dca_pkg::TMO_WIDTH-1:0] rc_tmo_r, upper_tmo_r, motor_tmo_r;

  logic [AGE_WIDTH-1:0] remote_age_r, upper_age_r, motor_age_r;
  logic [AGE_WIDTH-1:0] remote_age_nxt, upper_age_nxt, motor_age_nxt;
  logic remote_seen_ok_r, remote_enabled_r, remote_emergency_r;
  logic remote_seen_ok_nxt, remote_enabled_nxt, remote_emergency_nxt;
  logic [9:0] remote_steer_r, remote_drive_r, remote_steer_nxt, remote_drive_nxt;
  logic upper_seen_r, upper_stop_r, upper_run_r;
  logic upper_seen_nxt, upper_stop_nxt, upper_run_nxt;
  logic [31:0] upper_speed_r, upper_speed_nxt;
  logic motor_seen_r, motor_seen_nxt;
  logic [7:0] motor_fault_r, motor_fault_nxt;

  logic rc_ok, upper_fresh, motor_ok;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_tmo_r    <= dca_pkg::RC_TIMEOUT_RST;
      upper_tmo_r <= dca_pkg::UPPER_TIMEOUT_RST;
      motor_tmo_r <= dca_pkg::MOTOR_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == dca_pkg::CFG_RC_TIMEOUT) rc_tmo_r <= cfg_data;
      if (cfg_index == dca_pkg::CFG_UPPER_TIMEOUT) upper_tmo_r <= cfg_data;
      if (cfg_index == dca_pkg::CFG_MOTOR_TIMEOUT) motor_tmo_r <= cfg_data;
    end
  end

  // State update for the beat at the head of the pipe
  always_comb begin
    remote_age_nxt       = remote_age_r;
    upper_age_nxt        = upper_age_r;
    motor_age_nxt        = motor_age_r;
    remote_seen_ok_nxt   = remote_seen_ok_r;
    remote_enabled_nxt   = remote_enabled_r;
    remote_emergency_nxt = remote_emergency_r;
    remote_steer_nxt     = remote_steer_r;
    remote_drive_nxt     = remote_drive_r;
    upper_seen_nxt       = upper_seen_r;
    upper_stop_nxt       = upper_stop_r;
    upper_run_nxt        = upper_run_r;
    upper_speed_nxt      = upper_speed_r;
    motor_seen_nxt       = motor_seen_r;
    motor_fault_nxt      = motor_fault_r;
    unique case (stage.func)
      dca_pkg::FUNC_TICK: begin
        // saturating ages
        if (remote_age_r != AGE_MAX) remote_age_nxt = remote_age_r + AGE_ONE;
        if (upper_age_r != AGE_MAX) upper_age_nxt = upper_age_r + AGE_ONE;
        if (motor_age_r != AGE_MAX) motor_age_nxt = motor_age_r + AGE_ONE;
      end
      dca_pkg::FUNC_REMOTE: begin
        remote_age_nxt       = '0;
        remote_seen_ok_nxt   = !stage.link_lost;
        remote_enabled_nxt   = stage.enable_on;
        remote_emergency_nxt = stage.emergency_on;
        remote_steer_nxt     = dca_pkg::stick_finish_f(stage.steer);
        remote_drive_nxt     = dca_pkg::stick_finish_f(stage.drive);
      end
      dca_pkg::FUNC_UPPER_CMD: begin
        // stop request in byte 3 bit 0, run request in byte 4 bit 0
        upper_age_nxt  = '0;
        upper_seen_nxt = 1'b1;
        upper_stop_nxt = stage.can_payload[32];
        upper_run_nxt  = stage.can_payload[24];
      end
      dca_pkg::FUNC_UPPER_SPEED: begin
        upper_speed_nxt = stage.can_payload[63:32];
      end
      dca_pkg::FUNC_MOTOR: begin
        motor_age_nxt   = '0;
        motor_seen_nxt  = 1'b1;
        motor_fault_nxt = stage.can_payload[63:56];
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_age_r       <= AGE_MAX;
      upper_age_r        <= AGE_MAX;
      motor_age_r        <= AGE_MAX;
      remote_seen_ok_r   <= 1'b0;
      remote_enabled_r   <= 1'b0;
      remote_emergency_r <= 1'b0;
      remote_steer_r     <= '0;
      remote_drive_r     <= '0;
      upper_seen_r       <= 1'b0;
      upper_stop_r       <= 1'b0;
      upper_run_r        <= 1'b0;
      upper_speed_r      <= '0;
      motor_seen_r       <= 1'b0;
      motor_fault_r      <= '0;
    end else if (fire) begin
      remote_age_r       <= remote_age_nxt;
      upper_age_r        <= upper_age_nxt;
      motor_age_r        <= motor_age_nxt;
      remote_seen_ok_r   <= remote_seen_ok_nxt;
      remote_enabled_r   <= remote_enabled_nxt;
      remote_emergency_r <= remote_emergency_nxt;
      remote_steer_r     <= remote_steer_nxt;
      remote_drive_r     <= remote_drive_nxt;
      upper_seen_r       <= upper_seen_nxt;
      upper_stop_r       <= upper_stop_nxt;
      upper_run_r        <= upper_run_nxt;
      upper_speed_r      <= upper_speed_nxt;
      motor_seen_r       <= motor_seen_nxt;
      motor_fault_r      <= motor_fault_nxt;
    end
  end

  // Freshness, taken from the updated state
  assign rc_ok       = remote_seen_ok_nxt &&
                       (CMP_WIDTH'(remote_age_nxt) < CMP_WIDTH'(rc_tmo_r));
  assign upper_fresh = upper_seen_nxt &&
                       (CMP_WIDTH'(upper_age_nxt) < CMP_WIDTH'(upper_tmo_r));
  assign motor_ok    = motor_seen_nxt && (motor_fault_nxt == 8'd0) &&
                       (CMP_WIDTH'(motor_age_nxt) < CMP_WIDTH'(motor_tmo_r));

  // Arbitration by priority
  always_comb begin
    result.control_source   = dca_pkg::SRC_IDLE;
    result.command_kind     = dca_pkg::KIND_STOP;
    result.speed_axis_one   = '0;
    result.speed_axis_two   = '0;
    result.halt_cause       = dca_pkg::REASON_NONE;
    result.status_flags     = {upper_stop_nxt, remote_emergency_nxt, remote_enabled_nxt};
    result.motor_fault_code = motor_fault_nxt;
    priority if (upper_stop_nxt) begin
      result.halt_cause = dca_pkg::REASON_FORCED;
    end else if (remote_emergency_nxt) begin
      result.halt_cause = dca_pkg::REASON_EMERG;
    end else if (!motor_ok) begin
      result.halt_cause = (motor_seen_nxt && motor_fault_nxt != 8'd0) ?
                          dca_pkg::REASON_FAULT : dca_pkg::REASON_TIMEOUT;
    end else if (rc_ok && remote_enabled_nxt) begin
      result.control_source = dca_pkg::SRC_REMOTE;
      result.command_kind   = dca_pkg::KIND_SPEED;
      result.speed_axis_one = {{6{remote_steer_nxt[9]}}, remote_steer_nxt};
      result.speed_axis_two = {{6{remote_drive_nxt[9]}}, remote_drive_nxt};
    end else if (upper_fresh) begin
      result.control_source = dca_pkg::SRC_HOST;
      if (upper_run_nxt) begin
        result.command_kind   = dca_pkg::KIND_SPEED;
        result.speed_axis_one = upper_speed_nxt[31:16];
        result.speed_axis_two = upper_speed_nxt[15:0];
      end
    end else begin
      result.halt_cause = dca_pkg::REASON_TIMEOUT;
    end
  end

endmodule

>>> rtl/core/drive_command_arbiter.sv
// Top level of the drive command arbiter: input stage, core and result register.
//
// Arbitrates the front motor command between a radio remote and an upper
// controller. Each input beat is one event (millisecond tick, remote frame,
// upper command frame, upper speed frame or motor status frame); each beat
// yields exactly one result beat holding the arbitration after that event.
// Channels use valid/stall: a beat moves when valid is high and stall low.
// The configuration port (cfg_valid/cfg_ready) writes the three 16-bit
// timeout registers; cfg_ready is always high.
// Each beat passes the input register and then the result register:
// clamping, deadband and the first scaling multiply sit in front of the
// input register, and the reciprocal divide, state update and priority
// select sit between it and the result register. One beat per cycle is
// sustained while out_stall is low.
// When out_stall holds a result, one further beat waits in the input
// register; in_stall rises only when both are full.
// Synchronous reset (rst_n low) empties the pipe, marks every source stale
// and restores the timeout registers to their defaults.
`timescale 1ns / 1ps
module drive_command_arbiter #(
  parameter int AGE_WIDTH = dca_pkg::AGE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dca_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dca_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dca_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [dca_pkg::TMO_WIDTH-1:0]     cfg_data
);

  logic               s1_v_r;
  dca_pkg::stage_t    s1_r;
  logic               out_v_r;
  dca_pkg::out_item_t out_r;
  dca_pkg::out_item_t result;
  logic               out_free, s1_ready, fire;

  // Pipe control
  assign out_free  = !out_v_r || !out_stall;
  assign s1_ready  = !s1_v_r || out_free;
  assign fire      = s1_v_r && out_free;
  assign in_stall  = !s1_ready;
  assign cfg_ready = 1'b1;

  // Input register with stick prescaling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_r.func         <= in_data.func;
      s1_r.link_lost    <= in_data.link_lost;
      s1_r.enable_on    <= (in_data.enable_raw > dca_pkg::SWITCH_LEVEL);
      s1_r.emergency_on <= (in_data.emergency_raw > dca_pkg::SWITCH_LEVEL);
      s1_r.steer        <= dca_pkg::stick_prescale_f(in_data.stick_steer_raw);
      s1_r.drive        <= dca_pkg::stick_prescale_f(in_data.stick_drive_raw);
      s1_r.can_payload  <= in_data.can_payload;
    end
  end

  dca_core #(
    .AGE_WIDTH(AGE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .stage    (s1_r),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .result   (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Checks
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.halt_cause != dca_pkg::REASON_NONE) |->
      (out_data.command_kind == dca_pkg::KIND_STOP && out_data.speed_axis_one == 16'sd0 &&
       out_data.speed_axis_two == 16'sd0))
    else $error("stop result carries a speed");

  a_none_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.control_source == dca_pkg::SRC_IDLE) |->
      (out_data.halt_cause != dca_pkg::REASON_NONE))
    else $error("no source selected without a stop reason");

  a_remote_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.control_source == dca_pkg::SRC_REMOTE) |->
      (out_data.command_kind == dca_pkg::KIND_SPEED && out_data.status_flags[0]))
    else $error("remote selected without enable or speed command");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_v_r && out_stall))
    else $error("input stalled with room in the pipe");

endmodule
